@@ rtl/cawts_pkg.sv @@
// ----------------------------------------------------------------------------
// cawts_pkg
// Types and constants shared by the co-attack window texture scorer.
// ----------------------------------------------------------------------------
package cawts_pkg;

  localparam int NumVoices = 8;
  localparam int PairMax   = NumVoices * (NumVoices - 1) / 2;
  localparam int PairW     = $clog2(PairMax + 1);
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 7;
  localparam int ScoreW    = 7;

  localparam logic [CfgIdxW-1:0] CfgHighThr = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLowThr  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWinLen  = 2'd2;

  localparam logic [1:0] ClassBlack  = 2'd0;
  localparam logic [1:0] ClassOrange = 2'd1;
  localparam logic [1:0] ClassRed    = 2'd2;

  localparam logic [ScoreW-1:0] ScoreFull = 7'd100;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StUpdate,
    StPrep,
    StDiv,
    StOut
  } state_e;

  typedef struct packed {
    logic                 first_slice;
    logic [NumVoices-1:0] sounding_mask;
    logic [NumVoices-1:0] attack_mask;
  } in_item_t;

  typedef struct packed {
    logic [15:0]       window_start;
    logic [ScoreW-1:0] score_hundredths;
    logic [1:0]        texture_class;
    logic              no_pairs;
  } out_item_t;

endpackage

@@ rtl/cawts_ram.sv @@
// ----------------------------------------------------------------------------
// cawts_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cawts_ram #(
  parameter int Width = 10,
  parameter int Depth = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/co_attack_window_texture_scorer_top.sv @@
// ----------------------------------------------------------------------------
// co_attack_window_texture_scorer_top
// Per-slice voice pair counting over a sliding window, co-attack ratio in
// hundredths and texture classification.
//
// Channel   Dir  Handshake              Payload
// in        in   in_valid_i/in_stall_o  in_item_i  (in_item_t)
// out       out  out_valid_o/out_stall_i out_item_o (out_item_t)
// cfg       in   cfg_we_i               cfg_idx_i, cfg_data_i
//
// A slice goes through accept, ring read, update/write-back, divider setup,
// 7 restoring divider steps and output; a new one is taken only when idle.
// No-window slices end after the update; no-pair windows skip the divider.
// Ring contents are not cleared at reset; no clearing pass is needed.
// The result register holds while out_stall_i is high; the next slice is
// accepted meanwhile and waits in the output state if the register is full.
// ----------------------------------------------------------------------------
module co_attack_window_texture_scorer_top
  import cawts_pkg::*;
#(
  parameter int WINDOW_MAX = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int AW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int WW   = $clog2(WINDOW_MAX + 1);
  localparam int CmpW = (WW > 5) ? WW : 5;
  localparam int PtrW = WW + 1;
  localparam int SW   = $clog2(PairMax * WINDOW_MAX + 1);
  localparam int NW   = SW + 8;
  localparam int EW   = 2 * PairW;

  function automatic logic [3:0] popcnt8(input logic [NumVoices-1:0] m);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < NumVoices; i++) begin
      c = c + 4'(m[i]);
    end
    return c;
  endfunction

  function automatic logic [PairW-1:0] choose2(input logic [3:0] n);
    logic [7:0] prod;
    prod = 8'(n) * (8'(n) - ((n != 4'd0) ? 8'd1 : 8'd0));
    return PairW'(prod >> 1);
  endfunction

  state_e state_q, state_d;

  logic [6:0]        hi_thr_q, lo_thr_q;
  logic [4:0]        win_len_q;
  logic [SW-1:0]     pair_sum_q, att_sum_q;
  logic [WW-1:0]     fill_q;
  logic [AW-1:0]     ptr_q;
  logic [15:0]       slice_cnt_q;
  logic [15:0]       idx_q;
  logic [PairW-1:0]  p_q, a_q;
  logic [NW-1:0]     rem_q, dsh_q;
  logic [ScoreW-1:0] quot_q;
  logic [2:0]        step_q;
  logic              nop_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic              in_acc, out_acc, out_free;
  logic [CmpW-1:0]   wl_c;
  logic [WW-1:0]     w_eff;
  logic [PtrW-1:0]   old_sum;
  logic [PtrW-1:0]   old_wrap;
  logic [AW-1:0]     old_addr;
  logic              evict;
  logic [EW-1:0]     rdata;
  logic [SW-1:0]     pair_sum_n, att_sum_n;
  logic [WW-1:0]     fill_n;
  logic [NW-1:0]     numer;
  logic              ge;
  logic [6:0]        hi_t, lo_t;
  logic [ScoreW-1:0] score;
  logic [1:0]        cls;
  logic              ram_re, ram_we;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || !out_stall_i;

  assign wl_c = CmpW'(win_len_q);
  always_comb begin
    priority if (win_len_q == 5'd0) begin
      w_eff = WW'(1);
    end else if (wl_c > CmpW'(WINDOW_MAX)) begin
      w_eff = WW'(WINDOW_MAX);
    end else begin
      w_eff = WW'(wl_c);
    end
  end

  assign old_sum  = PtrW'(ptr_q) + PtrW'(WINDOW_MAX) - PtrW'(w_eff);
  assign old_wrap = (old_sum >= PtrW'(WINDOW_MAX)) ? old_sum - PtrW'(WINDOW_MAX) : old_sum;
  assign old_addr = old_wrap[AW-1:0];
  assign evict    = (fill_q >= w_eff);

  assign pair_sum_n = (evict ? pair_sum_q - SW'(rdata[EW-1:PairW]) : pair_sum_q) + SW'(p_q);
  assign att_sum_n  = (evict ? att_sum_q - SW'(rdata[PairW-1:0]) : att_sum_q) + SW'(a_q);
  assign fill_n     = evict ? w_eff : fill_q + WW'(1);

  // 200*A + P
  assign numer = (NW'(att_sum_q) << 7) + (NW'(att_sum_q) << 6) + (NW'(att_sum_q) << 3)
               + NW'(pair_sum_q);
  assign ge    = (rem_q >= dsh_q);

  assign hi_t  = (hi_thr_q > lo_thr_q) ? hi_thr_q : lo_thr_q;
  assign lo_t  = (hi_thr_q > lo_thr_q) ? lo_thr_q : hi_thr_q;
  assign score = nop_q ? '0 : ((quot_q > ScoreFull) ? ScoreFull : quot_q);
  always_comb begin
    priority if (nop_q) begin
      cls = ClassBlack;
    end else if (7'(score) >= hi_t) begin
      cls = ClassRed;
    end else if (7'(score) >= lo_t) begin
      cls = ClassOrange;
    end else begin
      cls = ClassBlack;
    end
  end

  assign ram_re = (state_q == StRead);
  assign ram_we = (state_q == StUpdate);

  cawts_ram #(
    .Width(EW),
    .Depth(WINDOW_MAX)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ptr_q),
    .wdata_i({p_q, a_q}),
    .re_i   (ram_re),
    .raddr_i(old_addr),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = StRead;
        end
      end
      StRead: state_d = StUpdate;
      StUpdate: state_d = (fill_n >= w_eff) ? StPrep : StIdle;
      StPrep: state_d = (pair_sum_q == '0) ? StOut : StDiv;
      StDiv: begin
        if (step_q == 3'd0) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      hi_thr_q    <= 7'd60;
      lo_thr_q    <= 7'd40;
      win_len_q   <= 5'd5;
      pair_sum_q  <= '0;
      att_sum_q   <= '0;
      fill_q      <= '0;
      ptr_q       <= '0;
      slice_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgHighThr: hi_thr_q <= cfg_data_i;
          CfgLowThr:  lo_thr_q <= cfg_data_i;
          CfgWinLen: begin
            win_len_q  <= cfg_data_i[4:0];
            pair_sum_q <= '0;
            att_sum_q  <= '0;
            fill_q     <= '0;
            ptr_q      <= '0;
          end
          default: ;
        endcase
      end
      if (in_acc) begin
        if (in_item_i.first_slice) begin
          pair_sum_q  <= '0;
          att_sum_q   <= '0;
          fill_q      <= '0;
          ptr_q       <= '0;
          slice_cnt_q <= 16'd1;
        end else begin
          slice_cnt_q <= slice_cnt_q + 16'd1;
        end
      end
      if (state_q == StUpdate) begin
        pair_sum_q <= pair_sum_n;
        att_sum_q  <= att_sum_n;
        fill_q     <= fill_n;
        ptr_q      <= (ptr_q == AW'(WINDOW_MAX - 1)) ? '0 : ptr_q + AW'(1);
      end
      if (state_q == StOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      idx_q <= in_item_i.first_slice ? 16'd0 : slice_cnt_q;
      p_q   <= choose2(popcnt8(in_item_i.sounding_mask));
      a_q   <= choose2(popcnt8(in_item_i.sounding_mask & in_item_i.attack_mask));
    end
    if (state_q == StPrep) begin
      rem_q  <= numer;
      dsh_q  <= NW'({pair_sum_q, 1'b0}) << 6;
      quot_q <= '0;
      step_q <= 3'd6;
      nop_q  <= (pair_sum_q == '0);
    end
    if (state_q == StDiv) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q  <= dsh_q >> 1;
      quot_q <= {quot_q[ScoreW-2:0], ge};
      step_q <= step_q - 3'd1;
    end
    if (state_q == StOut && out_free) begin
      out_q.window_start     <= idx_q - 16'(w_eff - WW'(1));
      out_q.score_hundredths <= score;
      out_q.texture_class    <= cls;
      out_q.no_pairs         <= nop_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ bench/tb_co_attack_window_texture_scorer_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_co_attack_window_texture_scorer_top
// Self-checking bench for the co-attack window texture scorer. Slices are
// offered through the valid/stall input channel and scored windows are taken
// from the output channel; a scoreboard class recomputes the voice pair
// counts, the sliding window sums, the rounded ratio and the texture class
// for every accepted slice and checks each result transaction against it.
// Covers reset settings, threshold order and extremes, window length edge
// values, empty windows, piece restarts, random idling on both sides and a
// long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_co_attack_window_texture_scorer_top;
  import cawts_pkg::*;

  localparam int WinMax       = 16;
  localparam int CycleLimit   = 2000000;
  localparam int SettleCycles = 16;
  localparam int LongHold     = 300;
  localparam int PhaseSlices  = 130;
  localparam int MaxPrinted   = 40;

  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  class window_scoreboard #(int Depth = 16);
    logic [PairW-1:0]         ring_pairs   [Depth];
    logic [PairW-1:0]         ring_attacks [Depth];
    logic [8:0]               pair_total;
    logic [8:0]               attack_total;
    logic [4:0]               filled;
    logic [$clog2(Depth)-1:0] wr_ptr;
    logic [15:0]              next_index;
    logic [CfgDataW-1:0]      thr_first;
    logic [CfgDataW-1:0]      thr_second;
    logic [4:0]               win_reg;
    out_item_t                due_windows [$];
    int errors;
    int slices;
    int windows;
    int empty_windows;
    int wraps;
    int class_seen [3];

    function void restart_window();
      pair_total   = '0;
      attack_total = '0;
      filled       = '0;
      wr_ptr       = '0;
    endfunction

    function void clear_state();
      for (int k = 0; k < Depth; k++) begin
        ring_pairs[k]   = '0;
        ring_attacks[k] = '0;
      end
      restart_window();
      next_index = '0;
      thr_first  = 7'd60;
      thr_second = 7'd40;
      win_reg    = 5'd5;
      errors = 0;
      slices = 0;
      windows = 0;
      empty_windows = 0;
      wraps = 0;
      class_seen = '{0, 0, 0};
    endfunction

    function int eff_window();
      if (win_reg == 0) return 1;
      if (win_reg > Depth) return Depth;
      return int'(win_reg);
    endfunction

    function int pair_count(logic [NumVoices-1:0] m);
      int n;
      n = $countones(m);
      return n * (n - 1) / 2;
    endfunction

    function int pending();
      return due_windows.size();
    endfunction

    function void note_config(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CfgHighThr: thr_first = val;
        CfgLowThr: thr_second = val;
        CfgWinLen: begin
          win_reg = val[4:0];
          restart_window();
        end
        default: ;
      endcase
    endfunction

    function void note_slice(in_item_t item);
      logic [NumVoices-1:0] snd;
      logic [NumVoices-1:0] att;
      logic [15:0]          idx;
      int w, p, a, old_slot, pt, at, score, hi, lo;
      out_item_t res;
      snd = item.sounding_mask;
      att = item.attack_mask & snd;
      w = eff_window();
      slices++;
      if (item.first_slice) begin
        restart_window();
        next_index = '0;
      end else if (next_index == 16'hFFFF) begin
        wraps++;
      end
      idx = next_index;
      next_index = next_index + 16'd1;
      p = pair_count(snd);
      a = pair_count(att);
      if (int'(filled) >= w) begin
        old_slot = (int'(wr_ptr) + Depth - w) % Depth;
        pair_total   = pair_total - 9'(ring_pairs[old_slot]);
        attack_total = attack_total - 9'(ring_attacks[old_slot]);
        filled = 5'(w);
      end else begin
        filled = filled + 5'd1;
      end
      ring_pairs[wr_ptr]   = PairW'(p);
      ring_attacks[wr_ptr] = PairW'(a);
      wr_ptr++;
      pair_total   = pair_total + 9'(p);
      attack_total = attack_total + 9'(a);
      if (int'(filled) < w) return;

      hi = (thr_first > thr_second) ? int'(thr_first) : int'(thr_second);
      lo = (thr_first > thr_second) ? int'(thr_second) : int'(thr_first);
      if (pair_total == 0) begin
        score = 0;
        res.texture_class = ClassBlack;
        res.no_pairs = 1'b1;
      end else begin
        pt = int'(pair_total);
        at = int'(attack_total);
        score = (200 * at + pt) / (2 * pt);
        if (score > int'(ScoreFull)) score = int'(ScoreFull);
        if (score >= hi) res.texture_class = ClassRed;
        else if (score >= lo) res.texture_class = ClassOrange;
        else res.texture_class = ClassBlack;
        res.no_pairs = 1'b0;
      end
      res.score_hundredths = ScoreW'(score);
      res.window_start = idx - 16'(w - 1);
      due_windows.push_back(res);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MaxPrinted) $display("ERROR at %0t: %s", $time, msg);
    endtask

    task check_window(out_item_t got);
      out_item_t want;
      if (due_windows.size() == 0) begin
        report_mismatch($sformatf("result with no window due (window_start %0d)",
                                  got.window_start));
        return;
      end
      want = due_windows.pop_front();
      windows++;
      if (want.no_pairs) empty_windows++;
      class_seen[want.texture_class]++;
      if (got.window_start !== want.window_start)
        report_mismatch($sformatf("window_start got %0d want %0d",
                                  got.window_start, want.window_start));
      if (got.score_hundredths !== want.score_hundredths)
        report_mismatch($sformatf("score_hundredths got %0d want %0d (window %0d)",
                                  got.score_hundredths, want.score_hundredths,
                                  want.window_start));
      if (got.texture_class !== want.texture_class)
        report_mismatch($sformatf("texture_class got %0d want %0d (window %0d)",
                                  got.texture_class, want.texture_class,
                                  want.window_start));
      if (got.no_pairs !== want.no_pairs)
        report_mismatch($sformatf("no_pairs got %0d want %0d (window %0d)",
                                  got.no_pairs, want.no_pairs, want.window_start));
    endtask
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_item_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  window_scoreboard #(WinMax) sb;

  bit quiet         = 1'b0;
  bit long_hold_req = 1'b0;
  int settings_used = 0;

  co_attack_window_texture_scorer_top #(
    .WINDOW_MAX(WinMax)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic in_item_t slice_of(bit first, logic [7:0] snd, logic [7:0] att);
    in_item_t item;
    item.first_slice   = first;
    item.sounding_mask = snd;
    item.attack_mask   = att;
    return item;
  endfunction

  function automatic in_item_t random_slice(bit first);
    logic [7:0] snd;
    logic [7:0] att;
    case ($urandom_range(0, 9))
      0: begin
        snd = 8'hFF;
        att = 8'hFF;
      end
      1: begin
        snd = 8'($urandom);
        att = 8'($urandom);
      end
      2: begin
        snd = 8'(1 << $urandom_range(0, 7));
        att = snd;
      end
      3: begin
        snd = 8'($urandom);
        att = snd;
      end
      default: begin
        snd = 8'($urandom);
        att = snd & 8'($urandom);
      end
    endcase
    return slice_of(first, snd, att);
  endfunction

  function automatic logic [CfgDataW-1:0] pick_threshold();
    logic [CfgDataW-1:0] extremes [4];
    extremes = '{7'd0, 7'd100, 7'd101, 7'd127};
    if ($urandom_range(0, 3) == 0) return extremes[$urandom_range(0, 3)];
    return 7'($urandom_range(0, 100));
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.note_config(idx, val);
  endtask

  task automatic program_regs(input logic [CfgDataW-1:0] hi, input logic [CfgDataW-1:0] lo,
                              input logic [CfgDataW-1:0] win);
    write_reg(CfgHighThr, hi);
    write_reg(CfgLowThr, lo);
    write_reg(CfgWinLen, win);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic offer_slice(input in_item_t item, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    sb.note_slice(item);
  endtask

  task automatic end_feed();
    in_valid_i <= 1'b0;
  endtask

  // slices that fill no window may still be in flight when the queue empties
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(input int quota, input logic [CfgDataW-1:0] hi,
                           input logic [CfgDataW-1:0] lo, input logic [CfgDataW-1:0] win);
    int done, len, w, odds, gap;
    bit first;
    program_regs(hi, lo, win);
    w = sb.eff_window();
    done = 0;
    first = 1'($urandom_range(0, 1));
    while (done < quota) begin
      if ($urandom_range(0, 7) == 0) len = $urandom_range(1, 20);
      else len = $urandom_range(w, w + 40);
      odds = quiet ? 0 : $urandom_range(0, 3);
      for (int k = 0; k < len; k++) begin
        gap = 0;
        if (odds != 0 && $urandom_range(1, 3 * odds) == 1) gap = $urandom_range(1, 12);
        offer_slice(random_slice(first), gap);
        first = 1'b0;
      end
      first = 1'b1;
      done += len;
    end
    end_feed();
    drain();
  endtask

  initial begin : receiver_side
    int hold_left, burst_left, odds, tick;
    hold_left = 0;
    burst_left = 0;
    odds = 2;
    tick = 0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (tick % 64 == 0) odds = $urandom_range(0, 3);
      if (long_hold_req) begin
        hold_left = LongHold;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall_i <= 1'b1;
      end else if (!quiet && odds != 0 && $urandom_range(1, 4 * odds) == 1) begin
        burst_left = $urandom_range(1, 12) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : result_monitor
    wait (sb != null);
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) sb.check_window(out_item_o);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d results still due", CycleLimit, sb.pending());
    $display("co_attack_window_texture_scorer_top: mismatch");
    $finish;
  end

  initial begin : stimulus
    logic [CfgDataW-1:0] win_plan [7];
    logic [CfgDataW-1:0] hi_thr;
    logic [CfgDataW-1:0] lo_thr;
    win_plan = '{7'd16, 7'd1, 7'd2, 7'd0, 7'd17, 7'd31, 7'h45};
    sb = new;
    sb.clear_state();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: window of 5, thresholds 60/40
    offer_slice(slice_of(1'b1, 8'hFF, 8'hFF), 0);
    offer_slice(slice_of(1'b0, 8'h00, 8'hFF), 0);
    offer_slice(slice_of(1'b0, 8'hFF, 8'h00), 0);
    offer_slice(slice_of(1'b0, 8'h0F, 8'hF0), 0);
    offer_slice(slice_of(1'b0, 8'hF0, 8'h3C), 0);
    offer_slice(slice_of(1'b0, 8'h55, 8'hAA), 0);
    end_feed();
    drain();

    write_reg(CfgUnused, 7'h7F);
    program_regs(7'd60, 7'd40, 7'd2);
    offer_slice(slice_of(1'b1, 8'h00, 8'h00), 0);
    offer_slice(slice_of(1'b0, 8'h00, 8'h00), 0);
    offer_slice(slice_of(1'b0, 8'hFF, 8'hFF), 0);
    offer_slice(slice_of(1'b0, 8'hFF, 8'h00), 0);
    offer_slice(slice_of(1'b0, 8'hFF, 8'h00), 0);
    offer_slice(slice_of(1'b0, 8'h03, 8'h03), 0);
    offer_slice(slice_of(1'b1, 8'hAA, 8'hAA), 0);
    offer_slice(slice_of(1'b0, 8'h01, 8'h01), 0);
    end_feed();
    drain();

    // thresholds written in reverse order
    program_regs(7'd20, 7'd80, 7'd1);
    offer_slice(slice_of(1'b1, 8'hFF, 8'hFF), 0);
    offer_slice(slice_of(1'b0, 8'hFF, 8'h07), 0);
    offer_slice(slice_of(1'b0, 8'hFF, 8'h3F), 0);
    offer_slice(slice_of(1'b0, 8'hFE, 8'h0E), 0);
    end_feed();
    drain();

    // classes never reached, window length 0
    program_regs(7'd101, 7'd101, 7'd0);
    offer_slice(slice_of(1'b0, 8'hFF, 8'hFF), 0);
    offer_slice(slice_of(1'b0, 8'h07, 8'h03), 0);
    end_feed();
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          hi_thr = 7'd101;
          lo_thr = 7'd101;
        end
        1: begin
          hi_thr = 7'd0;
          lo_thr = 7'd127;
        end
        2: begin
          hi_thr = 7'd30;
          lo_thr = 7'd70;
          long_hold_req = 1'b1;
        end
        default: begin
          hi_thr = pick_threshold();
          lo_thr = pick_threshold();
        end
      endcase
      run_phase(PhaseSlices, hi_thr, lo_thr, win_plan[ph]);
    end

    quiet = 1'b1;
    run_phase(PhaseSlices, pick_threshold(), pick_threshold(),
              7'($urandom_range(1, WinMax)));

    $display("Run covered %0d slices under %0d register settings, %0d windows checked (%0d empty).",
             sb.slices, settings_used, sb.windows, sb.empty_windows);
    $display("Classes black/orange/red: %0d/%0d/%0d, slice index wraps: %0d, errors: %0d.",
             sb.class_seen[0], sb.class_seen[1], sb.class_seen[2], sb.wraps, sb.errors);
    if (sb.errors == 0) begin
      $display("co_attack_window_texture_scorer_top: match");
    end else begin
      $display("co_attack_window_texture_scorer_top: mismatch");
    end
    $finish;
  end

endmodule
